// ----- hdl/ptpn_pkg.sv -----
// shared types, constants and tables of the pilot tone pll nco
`timescale 1ns / 1ps
package ptpn_pkg;

   localparam int PHASE_BITS_DEF  = 32;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_INCREMENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORM_BANDWIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NCO_MULTIPLIER  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_OFFSET    = 2'd3;

   localparam logic [15:0] NORM_BANDWIDTH_RST = 16'd655;
   localparam logic [3:0]  NCO_MULTIPLIER_RST = 4'd1;

   // atan2 approximation, turns * 2^28
   localparam logic [27:0] BASE_EIGHTH       = 28'd33554432;
   localparam logic [27:0] BASE_THREE_EIGHTH = 28'd100663296;
   localparam logic [25:0] POLY_LINEAR       = 26'd41940148;
   localparam logic [23:0] POLY_CUBIC        = 24'd8386491;

   // loop gain scale factors
   localparam logic [17:0] KP_SCALE = 18'd174719;
   localparam logic [17:0] KI_SCALE = 18'd232980;

   localparam logic [31:0] CORDIC_X0 = 32'd652032874;
   localparam int CORDIC_STEPS = 16;

   typedef struct packed {
      logic [31:0] phase_increment;
      logic [15:0] norm_bandwidth;
      logic [3:0]  nco_multiplier;
      logic [31:0] phase_offset;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MIX_I, ST_MIX_Q, ST_PREP, ST_DIV, ST_M2, ST_T1, ST_T2, ST_ERR,
      ST_KI, ST_KIR, ST_KIL, ST_KIH, ST_KP, ST_KPL, ST_KPH, ST_PH,
      ST_CL1, ST_CI1, ST_CD1, ST_CL2, ST_CI2, ST_CD2
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MIX_I, OP_MIX_Q, OP_PREP, OP_DIV, OP_M2, OP_T1, OP_T2,
      OP_ERR, OP_KI, OP_KIR, OP_KIL, OP_KIH, OP_KP, OP_KPL, OP_KPH, OP_PH,
      OP_CLOAD1, OP_CITER, OP_CDONE1, OP_CLOAD2, OP_CDONE2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] iter;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
   } status_type;

   // cordic arctangent table, turns * 2^32
   function automatic logic [31:0] arc_tab(input logic [3:0] i);
      logic [31:0] r;
      case (i)
         4'd0:  r = 32'd536870912;
         4'd1:  r = 32'd316933406;
         4'd2:  r = 32'd167458907;
         4'd3:  r = 32'd85004756;
         4'd4:  r = 32'd42667331;
         4'd5:  r = 32'd21354465;
         4'd6:  r = 32'd10679838;
         4'd7:  r = 32'd5340245;
         4'd8:  r = 32'd2670163;
         4'd9:  r = 32'd1335087;
         4'd10: r = 32'd667544;
         4'd11: r = 32'd333772;
         4'd12: r = 32'd166886;
         4'd13: r = 32'd83443;
         4'd14: r = 32'd41722;
         4'd15: r = 32'd20861;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/ptpn_req_if.sv -----
// sample channel interface
`timescale 1ns / 1ps
interface ptpn_req_if #(parameter int W = ptpn_pkg::SAMPLE_BITS_DEF);
   logic valid;
   logic ready;
   logic signed [W-1:0] sample_in;
   modport source(output valid, output sample_in, input ready);
   modport sink(input valid, input sample_in, output ready);
endinterface

// ----- hdl/ptpn_rsp_if.sv -----
// result channel interface
`timescale 1ns / 1ps
interface ptpn_rsp_if #(parameter int W = ptpn_pkg::SAMPLE_BITS_DEF);
   logic valid;
   logic ready;
   logic signed [W-1:0] nco_out;
   modport source(output valid, output nco_out, input ready);
   modport sink(input valid, input nco_out, output ready);
endinterface

// ----- hdl/ptpn_ctrl.sv -----
// sequencer of the loop update
`timescale 1ns / 1ps
module ptpn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ptpn_pkg::status_type   status,
   output ptpn_pkg::cmd_type      cmd,
   output logic                   idle
);

   ptpn_pkg::state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptpn_pkg::ST_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 5'd1;
      case (state_ff)
         ptpn_pkg::ST_IDLE:  if (start) state_in = ptpn_pkg::ST_MIX_I;
         ptpn_pkg::ST_MIX_I: state_in = ptpn_pkg::ST_MIX_Q;
         ptpn_pkg::ST_MIX_Q: state_in = ptpn_pkg::ST_PREP;
         ptpn_pkg::ST_PREP: begin
            state_in = ptpn_pkg::ST_DIV;
            cnt_in   = 5'd0;
         end
         // seventeen quotient bits, only one when the denominator is zero
         ptpn_pkg::ST_DIV: begin
            if (status.den_zero || cnt_ff == 5'd16) state_in = ptpn_pkg::ST_M2;
         end
         ptpn_pkg::ST_M2:  state_in = ptpn_pkg::ST_T1;
         ptpn_pkg::ST_T1:  state_in = ptpn_pkg::ST_T2;
         ptpn_pkg::ST_T2:  state_in = ptpn_pkg::ST_ERR;
         ptpn_pkg::ST_ERR: state_in = ptpn_pkg::ST_KI;
         ptpn_pkg::ST_KI:  state_in = ptpn_pkg::ST_KIR;
         ptpn_pkg::ST_KIR: state_in = ptpn_pkg::ST_KIL;
         ptpn_pkg::ST_KIL: state_in = ptpn_pkg::ST_KIH;
         ptpn_pkg::ST_KIH: state_in = ptpn_pkg::ST_KP;
         ptpn_pkg::ST_KP:  state_in = ptpn_pkg::ST_KPL;
         ptpn_pkg::ST_KPL: state_in = ptpn_pkg::ST_KPH;
         ptpn_pkg::ST_KPH: state_in = ptpn_pkg::ST_PH;
         ptpn_pkg::ST_PH:  state_in = ptpn_pkg::ST_CL1;
         ptpn_pkg::ST_CL1: begin
            state_in = ptpn_pkg::ST_CI1;
            cnt_in   = 5'd0;
         end
         ptpn_pkg::ST_CI1: if (cnt_ff == 5'(ptpn_pkg::CORDIC_STEPS - 1))
            state_in = ptpn_pkg::ST_CD1;
         ptpn_pkg::ST_CD1: state_in = ptpn_pkg::ST_CL2;
         ptpn_pkg::ST_CL2: begin
            state_in = ptpn_pkg::ST_CI2;
            cnt_in   = 5'd0;
         end
         ptpn_pkg::ST_CI2: if (cnt_ff == 5'(ptpn_pkg::CORDIC_STEPS - 1))
            state_in = ptpn_pkg::ST_CD2;
         ptpn_pkg::ST_CD2: state_in = ptpn_pkg::ST_IDLE;
         default: state_in = ptpn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.iter = cnt_ff[3:0];
      idle     = 1'b0;
      case (state_ff)
         ptpn_pkg::ST_IDLE: begin
            idle   = 1'b1;
            cmd.op = start ? ptpn_pkg::OP_LOAD : ptpn_pkg::OP_NONE;
         end
         ptpn_pkg::ST_MIX_I: cmd.op = ptpn_pkg::OP_MIX_I;
         ptpn_pkg::ST_MIX_Q: cmd.op = ptpn_pkg::OP_MIX_Q;
         ptpn_pkg::ST_PREP:  cmd.op = ptpn_pkg::OP_PREP;
         ptpn_pkg::ST_DIV:   cmd.op = ptpn_pkg::OP_DIV;
         ptpn_pkg::ST_M2:    cmd.op = ptpn_pkg::OP_M2;
         ptpn_pkg::ST_T1:    cmd.op = ptpn_pkg::OP_T1;
         ptpn_pkg::ST_T2:    cmd.op = ptpn_pkg::OP_T2;
         ptpn_pkg::ST_ERR:   cmd.op = ptpn_pkg::OP_ERR;
         ptpn_pkg::ST_KI:    cmd.op = ptpn_pkg::OP_KI;
         ptpn_pkg::ST_KIR:   cmd.op = ptpn_pkg::OP_KIR;
         ptpn_pkg::ST_KIL:   cmd.op = ptpn_pkg::OP_KIL;
         ptpn_pkg::ST_KIH:   cmd.op = ptpn_pkg::OP_KIH;
         ptpn_pkg::ST_KP:    cmd.op = ptpn_pkg::OP_KP;
         ptpn_pkg::ST_KPL:   cmd.op = ptpn_pkg::OP_KPL;
         ptpn_pkg::ST_KPH:   cmd.op = ptpn_pkg::OP_KPH;
         ptpn_pkg::ST_PH:    cmd.op = ptpn_pkg::OP_PH;
         ptpn_pkg::ST_CL1:   cmd.op = ptpn_pkg::OP_CLOAD1;
         ptpn_pkg::ST_CI1:   cmd.op = ptpn_pkg::OP_CITER;
         ptpn_pkg::ST_CD1:   cmd.op = ptpn_pkg::OP_CDONE1;
         ptpn_pkg::ST_CL2:   cmd.op = ptpn_pkg::OP_CLOAD2;
         ptpn_pkg::ST_CI2:   cmd.op = ptpn_pkg::OP_CITER;
         ptpn_pkg::ST_CD2:   cmd.op = ptpn_pkg::OP_CDONE2;
         default:            cmd.op = ptpn_pkg::OP_NONE;
      endcase
   end

endmodule

// ----- hdl/ptpn_dp.sv -----
// loop datapath: mixer, divider, shared multiplier, pi filter, cordic
`timescale 1ns / 1ps
module ptpn_dp #(
   parameter int PHASE_BITS  = ptpn_pkg::PHASE_BITS_DEF,
   parameter int SAMPLE_BITS = ptpn_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptpn_pkg::cmd_type             cmd,
   input  ptpn_pkg::cfg_type             cfg,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output ptpn_pkg::status_type          status,
   output logic signed [SAMPLE_BITS-1:0] held_out
);

   localparam int PB   = PHASE_BITS;
   localparam int SB   = SAMPLE_BITS;
   localparam int XW   = 2 * SB + 1;
   localparam int DW   = 2 * SB;
   localparam int RW   = DW + 1;
   localparam int AW   = 34;
   localparam int BW   = (SB > 19) ? SB : 19;
   localparam int PW   = AW + BW;
   localparam int EW   = 30;
   localparam int FW   = 66;
   localparam int KW   = 34;
   localparam int QW   = 17;
   localparam int CW   = 34;
   localparam int IW   = 40;
   localparam int IPSH = (PB >= 32) ? PB - 32 : 0;
   localparam int IPRS = (PB < 32) ? 32 - PB : 1;
   localparam int KPSH = 60 - PB;
   localparam int OSH  = 31 - SB;
   localparam logic signed [FW-1:0] SMAXF = signed'((FW'(1) << (SB - 1)) - FW'(1));
   localparam logic signed [IW-1:0] IMAX = signed'(IW'(32'h7fff_ffff));
   localparam logic signed [IW-1:0] IMIN = -IMAX - IW'(1);

   function automatic logic signed [FW-1:0] round_sh(input logic signed [FW-1:0] v,
                                                      input int sh);
      logic [FW-1:0] mag;
      mag = v[FW-1] ? FW'(-v) : FW'(v);
      mag = (mag + (FW'(1) << (sh - 1))) >> sh;
      return v[FW-1] ? -signed'(mag) : signed'(mag);
   endfunction

   function automatic logic signed [SB-1:0] to_sample(input logic signed [CW-1:0] v);
      logic signed [FW-1:0] r;
      r = round_sh(FW'(v), OSH);
      if (r > SMAXF) r = SMAXF;
      if (r < -SMAXF) r = -SMAXF;
      return r[SB-1:0];
   endfunction

   function automatic logic [PB-1:0] turns_to_pb(input logic [31:0] v);
      logic [PB+31:0] w;
      w = {v, PB'(0)};
      return w[PB+31 -: PB];
   endfunction

   function automatic logic [31:0] pb_to_turns(input logic [PB-1:0] v);
      logic [PB+31:0] w;
      w = {v, 32'd0};
      return w[PB+31 -: 32];
   endfunction

   logic signed [SB-1:0] s_ff, fc_ff, fs_ff, held_ff;
   logic signed [XW-1:0] x_ff;
   logic [DW-1:0]        den_ff;
   logic [RW-1:0]        r_ff;
   logic [QW-1:0]        q_ff;
   logic                 spec_ff, nneg_ff, yneg_ff, xneg_ff;
   logic signed [EW-1:0] e_ff;
   logic [KW-1:0]        ki_ff, kp_ff;
   logic signed [PW-1:0] acc_ff, prod_ff;
   logic signed [31:0]   integ_ff;
   logic [PB-1:0]        base_ff, est_ff, ph_ff, oph_ff;
   logic signed [CW-1:0] cx_ff, cy_ff, cz_ff;
   logic                 flip_ff;

   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;

   logic signed [XW-1:0] y_c, ay_c, ax_c, num_c;
   logic [DW-1:0]        den_c, an_c;
   logic [QW-1:0]        m_c;
   logic [25:0]          inner_c;
   logic signed [EW-1:0] base_c, e_c;
   logic [KW-1:0]        ki_c, kp_c;
   logic signed [FW-1:0] full_c, kpe_c;
   logic signed [IW-1:0] isum_c, isat_c;
   logic [PB-1:0]        ip_c, ph_c;
   logic [PB+3:0]        phm_c;
   logic [31:0]          p_c, arc_c;
   logic                 flip_c, div_t_c;
   logic [RW-1:0]        div_r_c;
   logic signed [CW-1:0] xs_c, ys_c, xf_c, yf_c;

   always_comb begin
      // phase detector prep
      y_c  = -prod_ff[XW-1:0];
      ay_c = y_c[XW-1] ? -y_c : y_c;
      ax_c = x_ff[XW-1] ? -x_ff : x_ff;
      num_c = x_ff[XW-1] ? x_ff + ay_c : x_ff - ay_c;
      den_c = DW'(ax_c + ay_c);
      an_c  = num_c[XW-1] ? DW'(-num_c) : DW'(num_c);
      // restoring divide step
      div_t_c = r_ff >= {1'b0, den_ff};
      div_r_c = div_t_c ? r_ff - {1'b0, den_ff} : r_ff;
      m_c = spec_ff ? QW'(17'h10000) : q_ff;
      inner_c = ptpn_pkg::POLY_LINEAR - {3'b000, prod_ff[38:16]};
      base_c = signed'(EW'(xneg_ff ? ptpn_pkg::BASE_THREE_EIGHTH : ptpn_pkg::BASE_EIGHTH));
      base_c = nneg_ff ? base_c + signed'(EW'(prod_ff[41:16]))
                       : base_c - signed'(EW'(prod_ff[41:16]));
      e_c = yneg_ff ? -base_c : base_c;
      ki_c = KW'((prod_ff + PW'(32768)) >>> 16);
      kp_c = prod_ff[KW-1:0];
      // two partial products, high one weighted by 2^17
      full_c = FW'(acc_ff) + (FW'(prod_ff) <<< 17);
      isum_c = IW'(integ_ff) + IW'(round_sh(full_c, 28));
      isat_c = (isum_c > IMAX) ? IMAX : ((isum_c < IMIN) ? IMIN : isum_c);
      kpe_c = round_sh(full_c, KPSH);
      if (PB >= 32) ip_c = PB'(FW'(integ_ff) <<< IPSH);
      else          ip_c = PB'(round_sh(FW'(integ_ff), IPRS));
      ph_c  = base_ff + est_ff;
      phm_c = {4'b0000, ph_c} * {PB'(0), cfg.nco_multiplier};
      // quadrant fold for the cordic
      p_c = pb_to_turns((cmd.op == ptpn_pkg::OP_CLOAD2) ? oph_ff : ph_ff);
      flip_c = (p_c >= 32'h4000_0000) && (p_c < 32'hc000_0000);
      if (flip_c) p_c = p_c - 32'h8000_0000;
      arc_c = ptpn_pkg::arc_tab(cmd.iter);
      xs_c = cx_ff >>> cmd.iter;
      ys_c = cy_ff >>> cmd.iter;
      xf_c = flip_ff ? -cx_ff : cx_ff;
      yf_c = flip_ff ? -cy_ff : cy_ff;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         ptpn_pkg::OP_MIX_I: begin
            mul_a = AW'(s_ff);
            mul_b = BW'(fc_ff);
         end
         ptpn_pkg::OP_MIX_Q: begin
            mul_a = AW'(s_ff);
            mul_b = BW'(fs_ff);
         end
         ptpn_pkg::OP_M2: begin
            mul_a = signed'(AW'(m_c));
            mul_b = signed'(BW'(m_c));
         end
         ptpn_pkg::OP_T1: begin
            mul_a = signed'(AW'(ptpn_pkg::POLY_CUBIC));
            mul_b = signed'(BW'(prod_ff[32:16]));
         end
         ptpn_pkg::OP_T2: begin
            mul_a = signed'(AW'(inner_c));
            mul_b = signed'(BW'(m_c));
         end
         ptpn_pkg::OP_ERR: begin
            mul_a = signed'(AW'(cfg.norm_bandwidth));
            mul_b = signed'(BW'(cfg.norm_bandwidth));
         end
         ptpn_pkg::OP_KI: begin
            mul_a = signed'(AW'(prod_ff[31:0]));
            mul_b = signed'(BW'(ptpn_pkg::KI_SCALE));
         end
         ptpn_pkg::OP_KIR: begin
            mul_a = AW'(e_ff);
            mul_b = signed'(BW'(ki_c[16:0]));
         end
         ptpn_pkg::OP_KIL: begin
            mul_a = AW'(e_ff);
            mul_b = signed'(BW'(ki_ff[KW-1:17]));
         end
         ptpn_pkg::OP_KIH: begin
            mul_a = signed'(AW'(cfg.norm_bandwidth));
            mul_b = signed'(BW'(ptpn_pkg::KP_SCALE));
         end
         ptpn_pkg::OP_KP: begin
            mul_a = AW'(e_ff);
            mul_b = signed'(BW'(kp_c[16:0]));
         end
         ptpn_pkg::OP_KPL: begin
            mul_a = AW'(e_ff);
            mul_b = signed'(BW'(kp_ff[KW-1:17]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         base_ff  <= '0;
         est_ff   <= '0;
         fc_ff    <= SB'(SMAXF);
         fs_ff    <= '0;
         held_ff  <= SB'(SMAXF);
         spec_ff  <= 1'b0;
      end else begin
         case (cmd.op)
            ptpn_pkg::OP_LOAD:  s_ff <= sample;
            ptpn_pkg::OP_MIX_Q: x_ff <= prod_ff[XW-1:0];
            ptpn_pkg::OP_PREP: begin
               den_ff  <= den_c;
               r_ff    <= RW'(an_c);
               q_ff    <= '0;
               spec_ff <= den_c == '0;
               nneg_ff <= (den_c == '0) || num_c[XW-1];
               yneg_ff <= y_c[XW-1];
               xneg_ff <= x_ff[XW-1];
            end
            ptpn_pkg::OP_DIV: begin
               r_ff <= {div_r_c[RW-2:0], 1'b0};
               q_ff <= {q_ff[QW-2:0], div_t_c};
            end
            ptpn_pkg::OP_ERR: e_ff <= e_c;
            ptpn_pkg::OP_KIR: ki_ff <= ki_c;
            ptpn_pkg::OP_KIL: acc_ff <= prod_ff;
            ptpn_pkg::OP_KIH: integ_ff <= isat_c[31:0];
            ptpn_pkg::OP_KP:  kp_ff <= kp_c;
            ptpn_pkg::OP_KPL: acc_ff <= prod_ff;
            ptpn_pkg::OP_KPH: begin
               est_ff  <= est_ff + PB'(kpe_c) + ip_c;
               base_ff <= base_ff + turns_to_pb(cfg.phase_increment);
            end
            ptpn_pkg::OP_PH: begin
               ph_ff  <= ph_c;
               oph_ff <= phm_c[PB-1:0] + turns_to_pb(cfg.phase_offset);
            end
            ptpn_pkg::OP_CLOAD1, ptpn_pkg::OP_CLOAD2: begin
               cx_ff   <= signed'(CW'(ptpn_pkg::CORDIC_X0));
               cy_ff   <= '0;
               cz_ff   <= CW'(signed'(p_c));
               flip_ff <= flip_c;
            end
            ptpn_pkg::OP_CITER: begin
               if (!cz_ff[CW-1]) begin
                  cx_ff <= cx_ff - ys_c;
                  cy_ff <= cy_ff + xs_c;
                  cz_ff <= cz_ff - signed'(CW'(arc_c));
               end else begin
                  cx_ff <= cx_ff + ys_c;
                  cy_ff <= cy_ff - xs_c;
                  cz_ff <= cz_ff + signed'(CW'(arc_c));
               end
            end
            ptpn_pkg::OP_CDONE1: begin
               fc_ff <= to_sample(xf_c);
               fs_ff <= to_sample(yf_c);
            end
            ptpn_pkg::OP_CDONE2: held_ff <= to_sample(xf_c);
            default: begin
            end
         endcase
      end
   end

   assign status.den_zero = spec_ff;
   assign held_out        = held_ff;

endmodule

// ----- hdl/pilot_tone_pll_nco.sv -----
// top level of the pilot tone pll with pi loop filter and nco
//
// One sample beat on req gives one result beat on rsp. The result is the nco
// cosine computed from the previous sample (cosine of zero after reset), so it
// is registered on rsp the cycle after the sample is accepted.
// Each sample then runs through the sequencer: mixer products, a 17-step
// restoring divider for the atan2 ratio, the error polynomial and split PI
// gain products on one shared multiplier, then two 16-step cordic passes for
// the feedback and the output phase. req is ready again once the sequencer
// is back in idle; the divider stops after its first step when both mixer
// products are zero.
// req_ready also needs the rsp register free or being taken, so a stalled
// receiver holds off the next sample and no result is dropped.
// csr_we writes register csr_index (0 phase increment, 1 bandwidth,
// 2 multiplier, 3 offset) at the clock edge; write only while idle.
// Synchronous reset clears the loop state, the registers to their defaults
// and drops rsp valid.
`timescale 1ns / 1ps
module pilot_tone_pll_nco #(
   parameter int PHASE_BITS  = ptpn_pkg::PHASE_BITS_DEF,
   parameter int SAMPLE_BITS = ptpn_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   ptpn_req_if.sink                               req,
   ptpn_rsp_if.source                             rsp,
   input  logic                                   csr_we,
   input  logic [ptpn_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ptpn_pkg::CSR_DATA_W-1:0]        csr_data
);

   ptpn_pkg::cfg_type    cfg_ff;
   ptpn_pkg::cmd_type    cmd;
   ptpn_pkg::status_type status;
   logic idle, accept;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, held;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_increment <= '0;
         cfg_ff.norm_bandwidth  <= ptpn_pkg::NORM_BANDWIDTH_RST;
         cfg_ff.nco_multiplier  <= ptpn_pkg::NCO_MULTIPLIER_RST;
         cfg_ff.phase_offset    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ptpn_pkg::CSR_PHASE_INCREMENT: cfg_ff.phase_increment <= csr_data;
            ptpn_pkg::CSR_NORM_BANDWIDTH:  cfg_ff.norm_bandwidth  <= csr_data[15:0];
            ptpn_pkg::CSR_NCO_MULTIPLIER:  cfg_ff.nco_multiplier  <= csr_data[3:0];
            ptpn_pkg::CSR_PHASE_OFFSET:    cfg_ff.phase_offset    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req.ready = idle && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // result beat is the cosine left by the previous sample
   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= held;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.nco_out = rsp_data_ff;

   ptpn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .status (status),
      .cmd    (cmd),
      .idle   (idle)
   );

   ptpn_dp #(
      .PHASE_BITS  (PHASE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg_ff),
      .sample   (req.sample_in),
      .status   (status),
      .held_out (held)
   );

`ifndef SYNTH
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("req ready right after a beat");
   a_result_after_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp.valid)
      else $error("no result after a beat");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.nco_out)))
      else $error("stalled result lost");
`endif

endmodule
